// ----- rtl/sr_pkg.sv -----
// Shared types, constants and saturation and rounding helpers for the reverberator.
`timescale 1ns / 1ps
`default_nettype none
package sr_pkg;

    localparam int LINE_W = 20;
    localparam int FRAC   = 15;
    localparam int GAIN_W = 15;
    localparam int MIX_W  = 16;
    localparam int CFG_AW = 3;

    localparam int BASE_CA = 1730;
    localparam int BASE_CB = 1494;
    localparam int BASE_CC = 1941;
    localparam int BASE_CD = 2156;
    localparam int BASE_AA = 240;
    localparam int BASE_AB = 81;
    localparam int BASE_AC = 23;

    localparam logic [MIX_W-1:0]  RST_WET  = 16'd22938;
    localparam logic [GAIN_W-1:0] RST_CA   = 15'd26378;
    localparam logic [GAIN_W-1:0] RST_CB   = 15'd27099;
    localparam logic [GAIN_W-1:0] RST_CC   = 15'd25657;
    localparam logic [GAIN_W-1:0] RST_CD   = 15'd25035;
    localparam logic [GAIN_W-1:0] RST_AP   = 15'd22938;
    localparam logic [MIX_W-1:0]  ONE_Q    = 16'd32768;

    typedef logic signed [LINE_W-1:0] t_line;
    typedef logic signed [2*LINE_W-5:0] t_prod;   // 20 x 16 signed product

    typedef enum logic [CFG_AW-1:0] {
        REG_WET_MIX = 3'd0,
        REG_COMB_A  = 3'd1,
        REG_COMB_B  = 3'd2,
        REG_COMB_C  = 3'd3,
        REG_COMB_D  = 3'd4,
        REG_AP_A    = 3'd5,
        REG_AP_B    = 3'd6,
        REG_AP_C    = 3'd7
    } t_reg_idx;

    // clamp to the signed line range
    function automatic t_line sat_line(input logic signed [23:0] v);
        if (v > 24'sd524287) begin
            return 20'sd524287;
        end else if (v < -24'sd524288) begin
            return -20'sd524288;
        end
        return v[LINE_W-1:0];
    endfunction

    // product / 2^15, rounded to nearest, halves up
    function automatic logic signed [23:0] rnd_q15(input t_prod p);
        t_prod t;
        t = (p + t_prod'(16384)) >>> FRAC;
        return t[23:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sr_comb.sv -----
// Feedback comb section: delay memory, gain multiply and write-back, three stages.
`timescale 1ns / 1ps
`default_nettype none
module sr_comb #(
    parameter int LEN = 3460
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire sr_pkg::t_line             i_x,
    input  wire logic [sr_pkg::GAIN_W-1:0] i_gain,
    output logic                           o_valid,
    output sr_pkg::t_line                  o_r
);
    import sr_pkg::*;

    localparam int AW = (LEN > 1) ? $clog2(LEN) : 1;

    t_line           r_mem [LEN];
    logic [AW-1:0]   r_ptr, n_ptr;
    logic            r_full;
    logic            r_v1, r_v2, r_v3;
    logic [AW-1:0]   r_a1, r_a2;
    t_line           r_x1, r_x2, r_rd, r_r2, r_r3;
    logic            r_z1;
    t_prod           r_p2;
    t_line           w_r1, n_wr;

    assign n_ptr = (r_ptr == AW'(LEN - 1)) ? '0 : r_ptr + 1'b1;
    // entries not yet written since reset read as zero
    assign w_r1  = r_z1 ? '0 : r_rd;
    assign n_wr  = sat_line(rnd_q15(r_p2) + 24'(r_x2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_valid) begin
                r_ptr <= n_ptr;
                if (r_ptr == AW'(LEN - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= !r_full;
            r_a1 <= r_ptr;
            r_x1 <= i_x;
            r_a2 <= r_a1;
            r_x2 <= r_x1;
            r_r2 <= w_r1;
            r_p2 <= t_prod'(w_r1 * $signed({1'b0, i_gain}));
            r_r3 <= r_r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[r_ptr];
            if (r_v2) begin
                r_mem[r_a2] <= n_wr;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_r     = r_r3;

endmodule
`default_nettype wire

// ----- rtl/sr_allpass.sv -----
// Schroeder allpass section: delay memory and two gain multiplies, four stages.
`timescale 1ns / 1ps
`default_nettype none
module sr_allpass #(
    parameter int LEN = 480
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire sr_pkg::t_line             i_x,
    input  wire logic [sr_pkg::GAIN_W-1:0] i_gain,
    output logic                           o_valid,
    output sr_pkg::t_line                  o_y
);
    import sr_pkg::*;

    localparam int AW = (LEN > 1) ? $clog2(LEN) : 1;

    t_line           r_mem [LEN];
    logic [AW-1:0]   r_ptr, n_ptr;
    logic            r_full;
    logic            r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]   r_a1, r_a2, r_a3;
    t_line           r_x1, r_x2, r_x3, r_rd, r_y2, r_y3, r_y4;
    logic            r_z1;
    t_prod           r_p1, r_p3;
    t_line           w_r1, n_wr;

    assign n_ptr = (r_ptr == AW'(LEN - 1)) ? '0 : r_ptr + 1'b1;
    assign w_r1  = r_z1 ? '0 : r_rd;
    assign n_wr  = sat_line(rnd_q15(r_p3) + 24'(r_x3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_valid) begin
                r_ptr <= n_ptr;
                if (r_ptr == AW'(LEN - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= !r_full;
            r_a1 <= r_ptr;
            r_x1 <= i_x;
            r_p1 <= t_prod'(i_x * $signed({1'b0, i_gain}));
            r_a2 <= r_a1;
            r_x2 <= r_x1;
            r_y2 <= sat_line(24'(w_r1) - rnd_q15(r_p1));
            r_a3 <= r_a2;
            r_x3 <= r_x2;
            r_y3 <= r_y2;
            r_p3 <= t_prod'(r_y2 * $signed({1'b0, i_gain}));
            r_y4 <= r_y3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[r_ptr];
            if (r_v3) begin
                r_mem[r_a3] <= n_wr;
            end
        end
    end

    assign o_valid = r_v4;
    assign o_y     = r_y4;

endmodule
`default_nettype wire

// ----- rtl/schroeder_reverb.sv -----
// One sample per cycle from input to output word while the output is not stalled.
// The whole pipeline advances together; a stalled output word freezes every stage.
// Throughput is set by the simple dual-port delay memories: one read and one write each cycle.
// Synchronous active-low reset clears valids, line pointers and configuration registers to defaults;
// delay lines read as zero until their pointer has wrapped once, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module schroeder_reverb #(
    parameter int DELAY_SCALE = 2,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [sr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [sr_pkg::MIX_W-1:0]  i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]    i_adc_sample,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [SAMPLE_BITS-1:0]         o_dac_sample,
    output logic                           o_clipped
);
    import sr_pkg::*;

    localparam int SMP_SHIFT = 16 - SAMPLE_BITS;
    localparam int OUT_RND   = (SMP_SHIFT == 0) ? 0 : (1 << (SMP_SHIFT - 1));
    localparam int XD        = 18;

    logic [MIX_W-1:0]  r_wet;
    logic [GAIN_W-1:0] r_gca, r_gcb, r_gcc, r_gcd, r_gaa, r_gab, r_gac;

    logic  en;
    logic  r_v0, r_vs, r_va, r_vm1, r_vm2, r_ov;
    t_line r_xd [XD];
    logic signed [LINE_W+1:0] r_sum;
    t_line r_y0;
    logic signed [36:0] r_pd, r_pw;
    logic signed [23:0] r_mix;
    logic [SAMPLE_BITS-1:0] r_dac;
    logic r_clip;

    logic  w_vca, w_vcb, w_vcc, w_vcd, w_vaa, w_vab, w_vac;
    t_line w_rca, w_rcb, w_rcc, w_rcd, w_yaa, w_yab, w_yac;
    logic signed [SAMPLE_BITS:0] w_c;
    t_line w_x;
    logic [MIX_W-1:0] w_wet;
    logic [MIX_W:0]   w_dry;
    logic signed [37:0] w_msum;
    logic signed [24:0] w_o;
    logic signed [LINE_W+1:0] w_avg;

    assign en         = !r_ov || i_out_ready;
    assign o_in_ready = en;

    assign w_c = $signed({1'b0, i_adc_sample})
               - $signed({1'b0, SAMPLE_BITS'(1 << (SAMPLE_BITS - 1))});
    assign w_x = LINE_W'(w_c) <<< SMP_SHIFT;

    assign w_wet  = (r_wet > ONE_Q) ? ONE_Q : r_wet;
    assign w_dry  = {1'b0, ONE_Q} - {1'b0, w_wet};
    assign w_msum = 38'(r_pd) + 38'(r_pw) + 38'sd16384;
    assign w_o    = ((25'(r_mix) + 25'sd0 + 25'(OUT_RND)) >>> SMP_SHIFT)
                  + 25'(1 << (SAMPLE_BITS - 1));
    assign w_avg  = (r_sum + 22'sd2) >>> 2;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet <= RST_WET;
            r_gca <= RST_CA;
            r_gcb <= RST_CB;
            r_gcc <= RST_CC;
            r_gcd <= RST_CD;
            r_gaa <= RST_AP;
            r_gab <= RST_AP;
            r_gac <= RST_AP;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_WET_MIX: r_wet <= i_cfg_data;
                REG_COMB_A:  r_gca <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_B:  r_gcb <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_C:  r_gcc <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_D:  r_gcd <= i_cfg_data[GAIN_W-1:0];
                REG_AP_A:    r_gaa <= i_cfg_data[GAIN_W-1:0];
                REG_AP_B:    r_gab <= i_cfg_data[GAIN_W-1:0];
                REG_AP_C:    r_gac <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vs  <= 1'b0;
            r_va  <= 1'b0;
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_v0  <= i_in_valid;
            r_vs  <= w_vca;
            r_va  <= r_vs;
            r_vm1 <= w_vac;
            r_vm2 <= r_vm1;
            r_ov  <= r_vm2;
        end
    end

    // dry sample travels alongside the wet path
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd[0] <= w_x;
            for (int i = 1; i < XD; i++) begin
                r_xd[i] <= r_xd[i-1];
            end
            r_sum <= 22'(w_rca) + 22'(w_rcb) + 22'(w_rcc) + 22'(w_rcd);
            r_y0  <= sat_line(24'(w_avg));
            r_pd  <= $signed({1'b0, w_dry}) * r_xd[XD-1];
            r_pw  <= $signed({1'b0, w_wet}) * w_yac;
            r_mix <= 24'(w_msum >>> FRAC);
            if (w_o < 0) begin
                r_dac  <= '0;
                r_clip <= 1'b1;
            end else if (w_o > 25'((1 << SAMPLE_BITS) - 1)) begin
                r_dac  <= '1;
                r_clip <= 1'b1;
            end else begin
                r_dac  <= w_o[SAMPLE_BITS-1:0];
                r_clip <= 1'b0;
            end
        end
    end

    sr_comb #(.LEN(BASE_CA * DELAY_SCALE)) u_comb_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0), .i_x(r_xd[0]),
        .i_gain(r_gca), .o_valid(w_vca), .o_r(w_rca));
    sr_comb #(.LEN(BASE_CB * DELAY_SCALE)) u_comb_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0), .i_x(r_xd[0]),
        .i_gain(r_gcb), .o_valid(w_vcb), .o_r(w_rcb));
    sr_comb #(.LEN(BASE_CC * DELAY_SCALE)) u_comb_c (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0), .i_x(r_xd[0]),
        .i_gain(r_gcc), .o_valid(w_vcc), .o_r(w_rcc));
    sr_comb #(.LEN(BASE_CD * DELAY_SCALE)) u_comb_d (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0), .i_x(r_xd[0]),
        .i_gain(r_gcd), .o_valid(w_vcd), .o_r(w_rcd));

    sr_allpass #(.LEN(BASE_AA * DELAY_SCALE)) u_ap_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_va), .i_x(r_y0),
        .i_gain(r_gaa), .o_valid(w_vaa), .o_y(w_yaa));
    sr_allpass #(.LEN(BASE_AB * DELAY_SCALE)) u_ap_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(w_vaa), .i_x(w_yaa),
        .i_gain(r_gab), .o_valid(w_vab), .o_y(w_yab));
    sr_allpass #(.LEN(BASE_AC * DELAY_SCALE)) u_ap_c (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(w_vab), .i_x(w_yab),
        .i_gain(r_gac), .o_valid(w_vac), .o_y(w_yac));

    assign o_out_valid  = r_ov;
    assign o_dac_sample = r_dac;
    assign o_clipped    = r_clip;

`ifndef ASSERT_OFF
    a_comb_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vca == w_vcb) && (w_vca == w_vcc) && (w_vca == w_vcd))
        else $error("comb sections out of step");
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_dac_sample == '0 || o_dac_sample == '1))
        else $error("clipped word not at a rail");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire
